// ===== hdl/owss_pkg.sv =====
package owss_pkg;

  // Operation codes of an input item
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_START = 2'd1,
    OP_PAIR  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_DIRECTION   = 3'd0,
    ST_FOUND       = 3'd1,
    ST_NO_RESPONSE = 3'd2,
    ST_NO_PRESENCE = 3'd3,
    ST_EXHAUSTED   = 3'd4,
    ST_STARTED     = 3'd5,
    ST_CLEARED     = 3'd6,
    ST_IGNORED     = 3'd7
  } status_e;

  // Positions below this one lie in the family byte
  localparam int FAMILY_LIMIT = 9;
  localparam int FAM_W = 4;

  typedef struct packed {
    logic [1:0] operation;
    logic       presence_ok;
    logic       id_bit;
    logic       complement_bit;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic               direction;
    logic [FAM_W-1:0]   family_discrepancy;
    logic               last_device;
  } result_t;

endpackage

// ===== hdl/onewire_rom_search_step_top.sv =====
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    operation_i, presence_ok_i, id_bit_i, complement_bit_i
// out      out_valid_o / out_ready_i  status_o, direction_o, rom_id_o, family_discrepancy_o, ...
//                                     (last_device_o)
//
// One item per cycle sustained while out_ready_i accepts results; out_valid_o rises once the item
// has passed from the input register through the decision logic into the result register.
// The search state updates in the cycle the item moves from input to result register.
// rst_ni clears the search state: ROM id 0, bit position 1, no pass open.
// A stalled output holds its result; the input register still takes one more item.
module onewire_rom_search_step_top #(
  parameter int ID_BITS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic               presence_ok_i,
  input  logic               id_bit_i,
  input  logic               complement_bit_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic               direction_o,
  output logic [ID_BITS-1:0] rom_id_o,
  output logic [3:0]         family_discrepancy_o,
  output logic               last_device_o
);

  logic                in_vld_q, in_vld_d;
  owss_pkg::item_t     item_q;
  logic                out_vld_q, out_vld_d;
  owss_pkg::result_t   res_q, res_d;
  logic [ID_BITS-1:0]  rom_q, rom_d;
  logic                step;
  logic                in_take;

  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;
  assign in_take    = in_valid_i && in_ready_o;

  assign in_vld_d  = in_take ? 1'b1 : (step ? 1'b0 : in_vld_q);
  assign out_vld_d = step ? 1'b1 : (out_ready_i ? 1'b0 : out_vld_q);

  owss_core #(
    .ID_BITS(ID_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (item_q),
    .result_o(res_d),
    .rom_id_o(rom_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.operation      <= operation_i;
      item_q.presence_ok    <= presence_ok_i;
      item_q.id_bit         <= id_bit_i;
      item_q.complement_bit <= complement_bit_i;
    end
    if (step) begin
      res_q <= res_d;
      rom_q <= rom_d;
    end
  end

  assign out_valid_o          = out_vld_q;
  assign status_o             = res_q.status;
  assign direction_o          = res_q.direction;
  assign rom_id_o             = rom_q;
  assign family_discrepancy_o = res_q.family_discrepancy;
  assign last_device_o        = res_q.last_device;

endmodule

// ===== hdl/owss_core.sv =====
module owss_core #(
  parameter int ID_BITS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  owss_pkg::item_t      item_i,
  output owss_pkg::result_t    result_o,
  output logic [ID_BITS-1:0]   rom_id_o
);

  localparam int PosW = $clog2(ID_BITS + 2);
  localparam int IdxW = $clog2(ID_BITS);

  logic [ID_BITS-1:0]            rom_q, rom_d;
  logic [PosW-1:0]               bitpos_q, bitpos_d;
  logic [PosW-1:0]               lastzero_q, lastzero_d;
  logic [PosW-1:0]               prevd_q, prevd_d;
  logic [owss_pkg::FAM_W-1:0]    fam_q, fam_d;
  logic                          done_q, done_d;
  logic                          pass_q, pass_d;

  logic [PosW-1:0] pos_m1;
  logic [IdxW-1:0] idx;
  logic            dir;
  owss_pkg::status_e status;

  assign pos_m1 = bitpos_q - PosW'(1);
  assign idx    = pos_m1[IdxW-1:0];

  always_comb begin
    rom_d      = rom_q;
    bitpos_d   = bitpos_q;
    lastzero_d = lastzero_q;
    prevd_d    = prevd_q;
    fam_d      = fam_q;
    done_d     = done_q;
    pass_d     = pass_q;
    status     = owss_pkg::ST_IGNORED;
    dir        = 1'b0;
    unique case (item_i.operation)
      owss_pkg::OP_CLEAR: begin
        prevd_d = '0;
        fam_d   = '0;
        done_d  = 1'b0;
        pass_d  = 1'b0;
        status  = owss_pkg::ST_CLEARED;
      end
      owss_pkg::OP_START: begin
        if (done_q) begin
          pass_d = 1'b0;
          status = owss_pkg::ST_EXHAUSTED;
        end else if (!item_i.presence_ok) begin
          prevd_d = '0;
          fam_d   = '0;
          done_d  = 1'b0;
          pass_d  = 1'b0;
          status  = owss_pkg::ST_NO_PRESENCE;
        end else begin
          bitpos_d   = PosW'(1);
          lastzero_d = '0;
          pass_d     = 1'b1;
          status     = owss_pkg::ST_STARTED;
        end
      end
      owss_pkg::OP_PAIR: begin
        if (pass_q) begin
          if (item_i.id_bit && item_i.complement_bit) begin
            pass_d = 1'b0;
            status = owss_pkg::ST_NO_RESPONSE;
          end else begin
            if (item_i.id_bit != item_i.complement_bit) begin
              dir = item_i.id_bit;
            end else begin
              // discrepancy: replay old path, take 1 at the last one, 0 beyond
              if (bitpos_q < prevd_q) begin
                dir = rom_q[idx];
              end else begin
                dir = (bitpos_q == prevd_q);
              end
              if (!dir) begin
                lastzero_d = bitpos_q;
                if (bitpos_q < PosW'(owss_pkg::FAMILY_LIMIT)) begin
                  fam_d = bitpos_q[owss_pkg::FAM_W-1:0];
                end
              end
            end
            rom_d[idx] = dir;
            if (bitpos_q >= PosW'(ID_BITS)) begin
              prevd_d = lastzero_d;
              if (lastzero_d == '0) begin
                done_d = 1'b1;
              end
              pass_d   = 1'b0;
              bitpos_d = PosW'(ID_BITS + 1);
              status   = owss_pkg::ST_FOUND;
            end else begin
              bitpos_d = bitpos_q + PosW'(1);
              status   = owss_pkg::ST_DIRECTION;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign result_o.status             = status;
  assign result_o.direction          = dir;
  assign result_o.family_discrepancy = fam_d;
  assign result_o.last_device        = done_d;
  assign rom_id_o                    = rom_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_q      <= '0;
      bitpos_q   <= PosW'(1);
      lastzero_q <= '0;
      prevd_q    <= '0;
      fam_q      <= '0;
      done_q     <= 1'b0;
      pass_q     <= 1'b0;
    end else if (step_i) begin
      rom_q      <= rom_d;
      bitpos_q   <= bitpos_d;
      lastzero_q <= lastzero_d;
      prevd_q    <= prevd_d;
      fam_q      <= fam_d;
      done_q     <= done_d;
      pass_q     <= pass_d;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int ID_BITS = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int MAX_DEVICES = 4;
  localparam int STALL_LIMIT = 500;
  localparam int RANDOM_ITEMS = 1450;
  localparam int NOISE_ITEMS = 150;

  typedef struct {
    owss_pkg::status_e          status;
    logic                       direction;
    logic [ID_BITS-1:0]         rom_id;
    logic [owss_pkg::FAM_W-1:0] family;
    logic                       last_device;
  } search_result_t;

  logic               clk;
  logic               rst_ni;
  logic               in_valid;
  logic               in_ready_o;
  logic [1:0]         operation;
  logic               presence_ok;
  logic               id_bit;
  logic               complement_bit;
  logic               out_valid_o;
  logic               out_ready;
  logic [2:0]         status_o;
  logic               direction_o;
  logic [ID_BITS-1:0] rom_id_o;
  logic [3:0]         family_discrepancy_o;
  logic               last_device_o;

  // search state mirror
  logic [ID_BITS-1:0]         rom_bits = '0;
  logic [6:0]                 bit_pos = 7'd1;
  logic [6:0]                 zero_branch_pos = '0;
  logic [6:0]                 last_disc = '0;
  logic [owss_pkg::FAM_W-1:0] fam_zero = '0;
  logic                       done_flag = 1'b0;
  logic                       pass_open = 1'b0;
  logic                       last_dir = 1'b0;

  search_result_t     search_results_due[$];
  int unsigned        fail_count = 0;
  int unsigned        sent_items = 0;
  int unsigned        idle_cycles = 0;
  int unsigned        in_quiet = 0;
  int unsigned        out_quiet = 0;

  // simulated bus population
  logic [ID_BITS-1:0] bus_ids[MAX_DEVICES];
  bit                 alive[MAX_DEVICES];
  int unsigned        dev_count = 0;

  onewire_rom_search_step_top #(
    .ID_BITS(ID_BITS)
  ) i_dut (
    .clk_i               (clk),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready_o),
    .operation_i         (operation),
    .presence_ok_i       (presence_ok),
    .id_bit_i            (id_bit),
    .complement_bit_i    (complement_bit),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready),
    .status_o            (status_o),
    .direction_o         (direction_o),
    .rom_id_o            (rom_id_o),
    .family_discrepancy_o(family_discrepancy_o),
    .last_device_o       (last_device_o)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_search();
    last_disc = '0;
    fam_zero  = '0;
    done_flag = 1'b0;
    pass_open = 1'b0;
  endfunction

  function automatic search_result_t predict_search_step(logic [1:0] op, logic pres,
                                                         logic idb, logic cmb);
    search_result_t r;
    logic [5:0]     idx;
    r.status = owss_pkg::ST_IGNORED;
    last_dir = 1'b0;
    if (op == owss_pkg::OP_CLEAR) begin
      clear_search();
      r.status = owss_pkg::ST_CLEARED;
    end else if (op == owss_pkg::OP_START) begin
      if (done_flag) begin
        pass_open = 1'b0;
        r.status = owss_pkg::ST_EXHAUSTED;
      end else if (!pres) begin
        clear_search();
        r.status = owss_pkg::ST_NO_PRESENCE;
      end else begin
        bit_pos         = 7'd1;
        zero_branch_pos = '0;
        pass_open       = 1'b1;
        r.status        = owss_pkg::ST_STARTED;
      end
    end else if (op == owss_pkg::OP_PAIR && pass_open) begin
      if (idb && cmb) begin
        pass_open = 1'b0;
        r.status = owss_pkg::ST_NO_RESPONSE;
      end else begin
        idx = 6'(bit_pos - 7'd1);
        if (idb != cmb) begin
          last_dir = idb;
        end else begin
          // discrepancy: follow old path, branch to 1 at the last one, 0 beyond
          if (bit_pos < last_disc) last_dir = rom_bits[idx];
          else last_dir = (bit_pos == last_disc);
          if (!last_dir) begin
            zero_branch_pos = bit_pos;
            if (bit_pos < owss_pkg::FAMILY_LIMIT) fam_zero = bit_pos[owss_pkg::FAM_W-1:0];
          end
        end
        rom_bits[idx] = last_dir;
        if (bit_pos >= ID_BITS) begin
          last_disc = zero_branch_pos;
          if (last_disc == 0) done_flag = 1'b1;
          pass_open = 1'b0;
          bit_pos   = 7'(ID_BITS + 1);
          r.status  = owss_pkg::ST_FOUND;
        end else begin
          bit_pos  = bit_pos + 7'd1;
          r.status = owss_pkg::ST_DIRECTION;
        end
      end
    end
    r.direction   = last_dir;
    r.rom_id      = rom_bits;
    r.family      = fam_zero;
    r.last_device = done_flag;
    return r;
  endfunction

  // wait cycles per item, with occasional stretches of back-to-back traffic
  function automatic int unsigned draw_wait(ref int unsigned quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 63) == 0) quiet = $urandom_range(20, 60);
    return $urandom_range(0, 3);
  endfunction

  task automatic send_item(logic [1:0] op, logic pres, logic idb, logic cmb);
    int unsigned gap;
    gap = draw_wait(in_quiet);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    operation      <= op;
    presence_ok    <= pres;
    id_bit         <= idb;
    complement_bit <= cmb;
    do @(posedge clk); while (!in_ready_o);
    search_results_due.push_back(predict_search_step(op, pres, idb, cmb));
    sent_items++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (search_results_due.size() != 0) @(posedge clk);
  endtask

  // wired-AND read of the id bit and its complement over the devices still in the pass
  task automatic send_bus_pair();
    logic [5:0] idx;
    logic       tbit;
    logic       cbit;
    idx  = 6'(bit_pos - 7'd1);
    tbit = 1'b1;
    cbit = 1'b1;
    for (int i = 0; i < dev_count; i++) begin
      if (alive[i]) begin
        tbit &= bus_ids[i][idx];
        cbit &= ~bus_ids[i][idx];
      end
    end
    send_item(owss_pkg::OP_PAIR, 1'($urandom), tbit, cbit);
    for (int i = 0; i < dev_count; i++) begin
      if (bus_ids[i][idx] != last_dir) alive[i] = 1'b0;
    end
  endtask

  task automatic build_population();
    logic [ID_BITS-1:0] rnd;
    logic [ID_BITS-1:0] upper;
    int unsigned        j;
    dev_count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, MAX_DEVICES);
    case ($urandom_range(0, 9))
      0: bus_ids[0] = '0;
      1: bus_ids[0] = '1;
      default: bus_ids[0] = {$urandom, $urandom};
    endcase
    for (int i = 1; i < dev_count; i++) begin
      bus_ids[i] = bus_ids[$urandom_range(0, i - 1)];
      // mostly branch inside the family byte
      j = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, ID_BITS - 1);
      bus_ids[i][j] = ~bus_ids[i][j];
      if ($urandom_range(0, 1)) begin
        rnd   = {$urandom, $urandom};
        upper = ~((64'd2 << j) - 64'd1);
        bus_ids[i] = (bus_ids[i] & ~upper) | (rnd & upper);
      end
    end
  endtask

  task automatic run_pass();
    int unsigned r;
    send_item(owss_pkg::OP_START,
              (dev_count > 0) ? ($urandom_range(0, 19) != 0) : 1'($urandom),
              1'($urandom), 1'($urandom));
    for (int i = 0; i < MAX_DEVICES; i++) alive[i] = 1'b1;
    while (pass_open) begin
      r = $urandom_range(0, 299);
      case (r)
        0: send_item(owss_pkg::OP_PAIR, 1'($urandom), 1'b1, 1'b1);
        1: begin
          send_item(owss_pkg::OP_START, 1'b1, 1'($urandom), 1'($urandom));
          for (int i = 0; i < MAX_DEVICES; i++) alive[i] = 1'b1;
        end
        2: send_item(OP_UNUSED, 1'($urandom), 1'($urandom), 1'($urandom));
        3: send_item(owss_pkg::OP_CLEAR, 1'($urandom), 1'($urandom), 1'($urandom));
        default: send_bus_pair();
      endcase
    end
  endtask

  task automatic test_ignored_codes();
    send_item(owss_pkg::OP_PAIR, 1'b1, 1'b0, 1'b1);
    send_item(OP_UNUSED, 1'b1, 1'b1, 1'b1);
    send_item(OP_UNUSED, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_search_reset();
    send_item(owss_pkg::OP_CLEAR, 1'b0, 1'b0, 1'b0);
    send_item(owss_pkg::OP_CLEAR, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_presence();
    send_item(owss_pkg::OP_START, 1'b0, 1'b0, 1'b0);
    send_item(owss_pkg::OP_START, 1'b1, 1'b1, 1'b0);
  endtask

  task automatic test_pair_rules();
    send_item(owss_pkg::OP_PAIR, 1'b0, 1'b1, 1'b0);
    send_item(owss_pkg::OP_PAIR, 1'b1, 1'b0, 1'b1);
    send_item(owss_pkg::OP_PAIR, 1'b0, 1'b0, 1'b0);
    // restart while the pass is open
    send_item(owss_pkg::OP_START, 1'b1, 1'b0, 1'b0);
    send_item(owss_pkg::OP_PAIR, 1'b1, 1'b0, 1'b0);
    send_item(owss_pkg::OP_PAIR, 1'b0, 1'b1, 1'b1);
    send_item(owss_pkg::OP_PAIR, 1'b0, 1'b0, 1'b1);
    send_item(owss_pkg::OP_START, 1'b0, 1'b1, 1'b1);
  endtask

  task automatic test_enumeration();
    int unsigned passes;
    int unsigned rounds;
    rounds = 0;
    while (sent_items < RANDOM_ITEMS) begin
      build_population();
      send_item(owss_pkg::OP_CLEAR, 1'($urandom), 1'($urandom), 1'($urandom));
      passes = 0;
      while (!done_flag && passes < 2 * dev_count + 4) begin
        run_pass();
        passes++;
      end
      send_item(owss_pkg::OP_START, 1'b1, 1'($urandom), 1'($urandom));
      if (rounds == 0 || $urandom_range(0, 3) == 0) wait_drained();
      rounds++;
    end
  endtask

  task automatic test_random_noise();
    repeat (NOISE_ITEMS) begin
      send_item(2'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    operation      = owss_pkg::OP_CLEAR;
    presence_ok    = 1'b0;
    id_bit         = 1'b0;
    complement_bit = 1'b0;
    repeat (4) @(negedge clk);
    rst_ni <= 1'b1;
    test_ignored_codes();
    test_search_reset();
    test_presence();
    test_pair_rules();
    test_enumeration();
    test_random_noise();
    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && search_results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait(out_quiet);
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid_o && out_ready));
    end
  end

  task automatic flag_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    search_result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (search_results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("%0t: result item with none pending", $time);
      end else begin
        want = search_results_due.pop_front();
        flag_field("status", 64'(want.status), 64'(status_o));
        flag_field("direction", 64'(want.direction), 64'(direction_o));
        flag_field("rom_id", want.rom_id, rom_id_o);
        flag_field("family_discrepancy", 64'(want.family), 64'(family_discrepancy_o));
        flag_field("last_device", 64'(want.last_device), 64'(last_device_o));
      end
    end
  end

  // no item moving on either side for too long means a hang
  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
